// ===== rtl/anb_pkg.sv =====
// ----------------------------------------------------------------------------
// anb_pkg - shared types and codes for the Annex B deframer
// Result kinds, deframer phases, the layout of one queued result and the data-byte step function.
// ----------------------------------------------------------------------------
`default_nettype none

package anb_pkg;

	// result kinds, carried on tuser
	localparam logic [1:0] KIND_HDR = 2'd0;   // unit header
	localparam logic [1:0] KIND_PAY = 2'd1;   // payload byte
	localparam logic [1:0] KIND_EOU = 2'd2;   // end of unit

	// deframer phase
	localparam logic [1:0] PH_SEARCH = 2'd0;
	localparam logic [1:0] PH_HDR    = 2'd1;
	localparam logic [1:0] PH_PAY    = 2'd2;

	// most results one input beat can cause
	localparam int MAX_RES = 5;
	localparam int RES_CW  = $clog2(MAX_RES + 1);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] ph;
		logic [1:0] pz;
	} pd_t;

	// one data byte leaving the unit: header if pending, else payload
	function automatic pd_t pd_step(input logic [1:0] ph, input logic [1:0] pz,
	                                input logic [7:0] b);
		pd_t r;
		if (ph == PH_HDR) begin
			r.kind = KIND_HDR;
			r.ph   = PH_PAY;
			r.pz   = 2'd0;
		end else begin
			r.kind = KIND_PAY;
			r.ph   = ph;
			if (b == 8'h00) begin
				r.pz = (pz < 2'd2) ? pz + 2'd1 : pz;
			end else begin
				r.pz = 2'd0;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/annexb_nal_deframer.sv =====
// ----------------------------------------------------------------------------
// annexb_nal_deframer - H.264 Annex B start code and emulation removal
// Splits a byte stream into units: header, payload bytes, end of unit.
// ----------------------------------------------------------------------------
// Usage:
//  - Input beats on s_*: one stream byte per beat in s_tdata, s_tlast set on
//    the final byte of the stream (held zeros are flushed, any open unit is
//    closed and the block starts searching again).
//  - Output beats on m_*: m_tuser gives the kind (header, payload, end of
//    unit), m_tdata the header fields and payload byte, m_tlast marks the
//    final result caused by one input byte. A byte may cause no result.
//  - Each input byte is decoded in the cycle it is accepted; its first
//    result enters the output register, or the queue if that is stalled.
//    Up to five results per byte are queued and drained, one beat per
//    cycle while m_tready is high. Throughput: one byte per cycle while each
//    byte gives at most one result and m_tready is high; a byte with more
//    results holds the output for one beat each. s_tready is low while queued
//    results remain; it is driven by the queue count alone, never by m_tready.
//  - When the receiver stalls, the output register holds its beat and the
//    queue fills; input is refused until the queue has emptied.
//  - Reset clears phase, zero counters, queue and output valid; the block
//    then discards bytes until the first start code.
`default_nettype none

module annexb_nal_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] stream_byte
	input  wire logic        s_tlast,   // stream_end
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [0] forbidden_bit, [2:1] ref_importance,
	                                    // [7:3] unit_type, [15:8] payload_byte
	output logic [1:0]       m_tuser,   // [1:0] kind
	output logic             m_tlast    // last result of this input beat
);
	import anb_pkg::*;

	// deframer state
	logic [1:0] phase_q, zero_run_q, held_q, pzr_q;

	// result queue (shifts towards entry 0) and output register
	res_t              que_q [MAX_RES];
	logic [RES_CW-1:0] que_n_q;
	res_t              out_q;
	logic              out_vld_q;

	logic accept, move;
	assign s_tready = (que_n_q == '0);
	assign accept   = s_tvalid & s_tready;
	assign move     = ~out_vld_q | m_tready;

	// ---- decode one byte: result list and next state ----
	res_t              gen   [MAX_RES];
	logic [RES_CW-1:0] gen_n;
	logic [1:0]        ph, zr, hz, pz;
	logic [1:0]        nx_phase, nx_zr, nx_hz, nx_pz;
	pd_t               r;

	always_comb begin
		for (int i = 0; i < MAX_RES; i++) begin
			gen[i] = '0;
		end
		gen_n = '0;
		ph    = phase_q;
		zr    = zero_run_q;
		hz    = held_q;
		pz    = pzr_q;
		r     = '0;

		if (ph == PH_HDR || ph == PH_PAY) begin
			if (s_tdata == 8'h00) begin
				if (hz == 2'd3) begin
					// fourth zero: oldest held zero goes out
					r = pd_step(ph, pz, 8'h00);
					gen[gen_n] = '{kind: r.kind, data: 8'h00, last: 1'b0};
					gen_n = gen_n + 1'b1;
					ph = r.ph;
					pz = r.pz;
				end else begin
					hz = hz + 2'd1;
				end
			end else if (s_tdata == 8'h01 && hz >= 2'd2) begin
				// next start code: its zeros are dropped
				hz = 2'd0;
				if (ph == PH_PAY) begin
					gen[gen_n] = '{kind: KIND_EOU, data: 8'h00, last: 1'b0};
					gen_n = gen_n + 1'b1;
				end
				ph = PH_HDR;
				pz = 2'd0;
			end else begin
				for (int i = 0; i < 3; i++) begin
					if (hz > 2'(i)) begin
						r = pd_step(ph, pz, 8'h00);
						gen[gen_n] = '{kind: r.kind, data: 8'h00, last: 1'b0};
						gen_n = gen_n + 1'b1;
						ph = r.ph;
						pz = r.pz;
					end
				end
				hz = 2'd0;
				if (s_tdata == 8'h03 && ph == PH_PAY && pz >= 2'd2) begin
					pz = 2'd0;  // emulation prevention byte
				end else begin
					r = pd_step(ph, pz, s_tdata);
					gen[gen_n] = '{kind: r.kind, data: s_tdata, last: 1'b0};
					gen_n = gen_n + 1'b1;
					ph = r.ph;
					pz = r.pz;
				end
			end
		end else begin
			ph = PH_SEARCH;
			if (s_tdata == 8'h00) begin
				if (zr < 2'd3) begin
					zr = zr + 2'd1;
				end
			end else if (s_tdata == 8'h01 && zr >= 2'd2) begin
				ph = PH_HDR;
				zr = 2'd0;
				hz = 2'd0;
				pz = 2'd0;
			end else begin
				zr = 2'd0;
			end
		end

		// end of stream: flush held zeros, close the unit, start over
		if (s_tlast) begin
			if (ph == PH_HDR || ph == PH_PAY) begin
				for (int i = 0; i < 3; i++) begin
					if (hz > 2'(i)) begin
						r = pd_step(ph, pz, 8'h00);
						gen[gen_n] = '{kind: r.kind, data: 8'h00, last: 1'b0};
						gen_n = gen_n + 1'b1;
						ph = r.ph;
						pz = r.pz;
					end
				end
				if (ph == PH_PAY) begin
					gen[gen_n] = '{kind: KIND_EOU, data: 8'h00, last: 1'b0};
					gen_n = gen_n + 1'b1;
				end
			end
			ph = PH_SEARCH;
			zr = 2'd0;
			hz = 2'd0;
			pz = 2'd0;
		end

		for (int i = 0; i < MAX_RES; i++) begin
			gen[i].last = (gen_n == RES_CW'(i + 1));
		end

		nx_phase = ph;
		nx_zr    = zr;
		nx_hz    = hz;
		nx_pz    = pz;
	end

	// ---- queue source: fresh decode on accept, else what is queued ----
	res_t              src   [MAX_RES];
	logic [RES_CW-1:0] src_n;

	always_comb begin
		for (int i = 0; i < MAX_RES; i++) begin
			src[i] = accept ? gen[i] : que_q[i];
		end
		src_n = accept ? gen_n : que_n_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SEARCH;
			zero_run_q <= 2'd0;
			held_q     <= 2'd0;
			pzr_q      <= 2'd0;
			que_n_q    <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (accept) begin
				phase_q    <= nx_phase;
				zero_run_q <= nx_zr;
				held_q     <= nx_hz;
				pzr_q      <= nx_pz;
			end
			if (move) begin
				out_vld_q <= (src_n != '0);
				que_n_q   <= (src_n != '0) ? src_n - 1'b1 : '0;
			end else begin
				que_n_q   <= src_n;
			end
		end
	end

	// payload side of queue and output register, no reset needed
	always_ff @(posedge clk) begin
		if (move) begin
			out_q <= src[0];
			for (int i = 0; i < MAX_RES - 1; i++) begin
				que_q[i] <= src[i + 1];
			end
			que_q[MAX_RES - 1] <= '0;
		end else begin
			for (int i = 0; i < MAX_RES; i++) begin
				que_q[i] <= src[i];
			end
		end
	end

	// ---- output fields ----
	logic is_hdr, is_pay;
	assign is_hdr = (out_q.kind == KIND_HDR);
	assign is_pay = (out_q.kind == KIND_PAY);

	assign m_tvalid      = out_vld_q;
	assign m_tuser       = out_q.kind;
	assign m_tlast       = out_q.last;
	assign m_tdata[0]    = is_hdr ? out_q.data[7]   : 1'b0;
	assign m_tdata[2:1]  = is_hdr ? out_q.data[6:5] : 2'd0;
	assign m_tdata[7:3]  = is_hdr ? out_q.data[4:0] : 5'd0;
	assign m_tdata[15:8] = is_pay ? out_q.data      : 8'd0;

endmodule

`default_nettype wire
